// ===== rtl/core/bpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared codes and types of the breakpoint envelope table.
// ----------------------------------------------------------------------------
`default_nettype none

package bpe_pkg;

   localparam int VALUE_W  = 32;
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_EVAL   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // cell operations
   localparam logic [1:0] CELL_HOLD  = 2'd0;
   localparam logic [1:0] CELL_LOAD  = 2'd1;
   localparam logic [1:0] CELL_LEFT  = 2'd2;
   localparam logic [1:0] CELL_RIGHT = 2'd3;

   typedef struct packed {
      logic [1:0] op;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/bpe_cell.sv =====
// ----------------------------------------------------------------------------
// bpe_cell
// One breakpoint slot: holds a point, shifts to or from its neighbors and
// flags whether it holds a point and its frame lies below the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_cell #(
   parameter int FRAME_BITS = 40,
   parameter int CNT_W      = 7,
   parameter int SLOT       = 0
) (
   input  wire                             clock,
   input  bpe_pkg::cell_ctrl_type          ctrl,
   input  wire [FRAME_BITS-1:0]            key_frame,
   input  wire signed [bpe_pkg::VALUE_W-1:0] key_value,
   input  wire [CNT_W-1:0]                 count,
   input  wire [FRAME_BITS-1:0]            left_frame,
   input  wire signed [bpe_pkg::VALUE_W-1:0] left_value,
   input  wire [FRAME_BITS-1:0]            right_frame,
   input  wire signed [bpe_pkg::VALUE_W-1:0] right_value,
   output logic [FRAME_BITS-1:0]           frame,
   output logic signed [bpe_pkg::VALUE_W-1:0] value,
   output logic                            below
);

   logic [FRAME_BITS-1:0]              frame_ff, frame_in;
   logic signed [bpe_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                               below_ff, below_in;

   always_comb begin
      frame_in = frame_ff;
      value_in = value_ff;
      case (ctrl.op)
         bpe_pkg::CELL_LOAD: begin
            frame_in = key_frame;
            value_in = key_value;
         end
         bpe_pkg::CELL_LEFT: begin
            frame_in = left_frame;
            value_in = left_value;
         end
         bpe_pkg::CELL_RIGHT: begin
            frame_in = right_frame;
            value_in = right_value;
         end
         default: ;
      endcase
      below_in = (CNT_W'(SLOT) < count) && (frame_ff < key_frame);
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      value_ff <= value_in;
      below_ff <= below_in;
   end

   assign frame = frame_ff;
   assign value = value_ff;
   assign below = below_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bpe_div.sv =====
// ----------------------------------------------------------------------------
// bpe_div
// Restoring fraction divider: floor(num * 2^FRAC_BITS / den), saturating at
// one when num reaches den. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_div #(
   parameter int NUM_W     = 40,
   parameter int FRAC_BITS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire [NUM_W-1:0]      num,
   input  wire [NUM_W-1:0]      den,
   output logic                 done,
   output logic [FRAC_BITS:0]   quot
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [NUM_W-1:0]   den_ff, den_in;
   logic [FRAC_BITS:0] quo_ff, quo_in;
   logic [NUM_W:0]     shifted;
   logic               ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, 1'b0};
      ge      = shifted >= {1'b0, den_ff};
      if (start) begin
         den_in = den;
         if (num >= den) begin
            quo_in  = (FRAC_BITS+1)'(1) << FRAC_BITS;
            done_in = 1'b1;
         end else begin
            rem_in  = num;
            quo_in  = '0;
            cnt_in  = CNT_W'(FRAC_BITS);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? NUM_W'(shifted - {1'b0, den_ff}) : shifted[NUM_W-1:0];
         quo_in = {quo_ff[FRAC_BITS-1:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/core/breakpoint_envelope_table.sv =====
// Each item passes compare, select, execute and done steps; done waits for a
// free response register. Update drops the old point and repeats compare,
// select and execute; evaluate adds divide (one quotient bit per cycle),
// multiply and add steps when it starts a division. One item at a time: the
// next item is taken once the result is in the output register.
// Reset empties the table (count 0) and clears the clip length; the point
// slots themselves keep whatever they held.
// ----------------------------------------------------------------------------
// breakpoint_envelope_table
// Sorted breakpoint table in a row of shifting cells with a piecewise-linear
// envelope evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_envelope_table #(
   parameter int MAX_POINTS = 64,
   parameter int FRAME_BITS = 40,
   parameter int FRAC_BITS  = 16
) (
   input  wire clock,
   input  wire reset,
   // tuser: func
   input  wire [bpe_pkg::FUNC_W-1:0] req_tuser,
   // tdata: frame, point_value, index
   input  wire [((FRAME_BITS+bpe_pkg::VALUE_W+$clog2(MAX_POINTS))+7)/8*8-1:0] req_tdata,
   input  wire  req_tvalid,
   output logic req_tready,
   // tdata: status, out_position, envelope, points_held
   output logic [((bpe_pkg::STATUS_W+$clog2(MAX_POINTS)+bpe_pkg::VALUE_W
                  +$clog2(MAX_POINTS+1))+7)/8*8-1:0] rsp_tdata,
   output logic rsp_tvalid,
   input  wire  rsp_tready,
   input  wire [FRAME_BITS-1:0] csr_data,
   input  wire  csr_valid,
   output logic csr_ready
);

   localparam int PW     = $clog2(MAX_POINTS);
   localparam int CW     = $clog2(MAX_POINTS + 1);
   localparam int VW     = bpe_pkg::VALUE_W;
   localparam int SW     = bpe_pkg::STATUS_W;
   localparam int REQ_DW = ((FRAME_BITS + VW + PW) + 7) / 8 * 8;
   localparam int RSP_DW = ((SW + PW + VW + CW) + 7) / 8 * 8;
   localparam int TW     = FRAC_BITS + 2;
   localparam int PRW    = VW + 1 + TW;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CMP  = 3'd1;
   localparam logic [2:0] ST_SEL  = 3'd2;
   localparam logic [2:0] ST_EXEC = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_MUL  = 3'd5;
   localparam logic [2:0] ST_ADD  = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   localparam logic [1:0] TM_NONE  = 2'd0;
   localparam logic [1:0] TM_LOAD  = 2'd1;
   localparam logic [1:0] TM_PLACE = 2'd2;
   localparam logic [1:0] TM_DROP  = 2'd3;

   // control state
   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [FRAME_BITS-1:0] clip_ff, clip_in;
   logic                upd_ff, upd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                div_start_ff, div_start_in;

   // item
   logic [bpe_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [FRAME_BITS-1:0] key_ff, key_in;
   logic signed [VW-1:0]  val_ff, val_in;
   logic [PW-1:0]         idx_ff, idx_in;

   // selection
   logic [PW-1:0]         pos_ff, pos_in;
   logic                  first_ff, first_in;
   logic [FRAME_BITS-1:0] hi_f_ff, hi_f_in, lo_f_ff, lo_f_in, last_f_ff, last_f_in;
   logic signed [VW-1:0]  hi_v_ff, hi_v_in, lo_v_ff, lo_v_in, last_v_ff, last_v_in;

   // arithmetic
   logic [FRAME_BITS-1:0] num_ff, num_in, den_ff, den_in;
   logic signed [VW:0]    coef_ff, coef_in;
   logic signed [VW-1:0]  base_ff, base_in;
   logic                  inv_ff, inv_in;
   logic signed [PRW-1:0] prod_ff, prod_in;

   // result
   logic [SW-1:0]         res_st_ff, res_st_in;
   logic [PW-1:0]         res_pos_ff, res_pos_in;
   logic signed [VW-1:0]  res_env_ff, res_env_in;
   logic [RSP_DW-1:0]     rsp_data_ff, rsp_data_in;

   logic [1:0]            tbl_mode;
   logic [PW-1:0]         tbl_at;

   logic [FRAME_BITS-1:0] cell_frame [MAX_POINTS];
   logic signed [VW-1:0]  cell_value [MAX_POINTS];
   logic [MAX_POINTS-1:0] cell_below;
   logic [MAX_POINTS-1:0] bnd;
   bpe_pkg::cell_ctrl_type cell_ctrl [MAX_POINTS];

   logic                  div_done;
   logic [FRAC_BITS:0]    div_quot;
   logic signed [TW-1:0]  tt;
   logic signed [PRW-1:0] scaled;
   logic                  req_fire;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // row of cells
   for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
      logic [FRAME_BITS-1:0] lf, rf;
      logic signed [VW-1:0]  lv, rv;

      if (g == 0) begin : g_first
         assign lf = '0;
         assign lv = '0;
      end else begin : g_mid
         assign lf = cell_frame[g-1];
         assign lv = cell_value[g-1];
      end
      if (g == MAX_POINTS - 1) begin : g_last
         assign rf = '0;
         assign rv = '0;
      end else begin : g_inner
         assign rf = cell_frame[g+1];
         assign rv = cell_value[g+1];
      end

      always_comb begin
         cell_ctrl[g].op = bpe_pkg::CELL_HOLD;
         case (tbl_mode)
            TM_LOAD: begin
               if (PW'(g) == tbl_at) cell_ctrl[g].op = bpe_pkg::CELL_LOAD;
            end
            TM_PLACE: begin
               if (PW'(g) == tbl_at) cell_ctrl[g].op = bpe_pkg::CELL_LOAD;
               else if (PW'(g) > tbl_at) cell_ctrl[g].op = bpe_pkg::CELL_LEFT;
            end
            TM_DROP: begin
               if (PW'(g) >= tbl_at) cell_ctrl[g].op = bpe_pkg::CELL_RIGHT;
            end
            default: ;
         endcase
      end

      bpe_cell #(
         .FRAME_BITS (FRAME_BITS),
         .CNT_W      (CW),
         .SLOT       (g)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[g]),
         .key_frame   (key_ff),
         .key_value   (val_ff),
         .count       (count_ff),
         .left_frame  (lf),
         .left_value  (lv),
         .right_frame (rf),
         .right_value (rv),
         .frame       (cell_frame[g]),
         .value       (cell_value[g]),
         .below       (cell_below[g])
      );

      // first slot whose frame is not below the key
      if (g == 0) begin : g_bnd0
         assign bnd[g] = !cell_below[g];
      end else begin : g_bndn
         assign bnd[g] = cell_below[g-1] && !cell_below[g];
      end
   end

   bpe_div #(
      .NUM_W     (FRAME_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // gather the boundary points
   always_comb begin
      pos_in    = pos_ff;
      hi_f_in   = hi_f_ff;
      hi_v_in   = hi_v_ff;
      lo_f_in   = lo_f_ff;
      lo_v_in   = lo_v_ff;
      last_f_in = last_f_ff;
      last_v_in = last_v_ff;
      first_in  = first_ff;
      if (state_ff == ST_SEL) begin
         pos_in    = '0;
         hi_f_in   = '0;
         hi_v_in   = '0;
         lo_f_in   = '0;
         lo_v_in   = '0;
         last_f_in = '0;
         last_v_in = '0;
         first_in  = !cell_below[0];
         for (int i = 0; i < MAX_POINTS; i++) begin
            if (bnd[i]) begin
               pos_in  = pos_in | PW'(i);
               hi_f_in = hi_f_in | cell_frame[i];
               hi_v_in = hi_v_in | cell_value[i];
               if (i > 0) begin
                  lo_f_in = lo_f_in | cell_frame[(i+MAX_POINTS-1)%MAX_POINTS];
                  lo_v_in = lo_v_in | cell_value[(i+MAX_POINTS-1)%MAX_POINTS];
               end
            end
            if (CW'(i) == count_ff - CW'(1)) begin
               last_f_in = last_f_in | cell_frame[i];
               last_v_in = last_v_in | cell_value[i];
            end
         end
      end
   end

   assign tt     = inv_ff ? TW'((TW)'(1) << FRAC_BITS) - TW'(div_quot) : TW'(div_quot);
   assign scaled = prod_ff >>> FRAC_BITS;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      clip_in      = clip_ff;
      upd_in       = upd_ff;
      rsp_valid_in = rsp_valid_ff;
      div_start_in = 1'b0;
      func_in      = func_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      coef_in      = coef_ff;
      base_in      = base_ff;
      inv_in       = inv_ff;
      prod_in      = prod_ff;
      res_st_in    = res_st_ff;
      res_pos_in   = res_pos_ff;
      res_env_in   = res_env_ff;
      rsp_data_in  = rsp_data_ff;
      tbl_mode     = TM_NONE;
      tbl_at       = '0;

      if (csr_valid) clip_in = csr_data;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in    = req_tuser;
               key_in     = req_tdata[FRAME_BITS-1:0];
               val_in     = req_tdata[FRAME_BITS+VW-1:FRAME_BITS];
               idx_in     = req_tdata[FRAME_BITS+VW+PW-1:FRAME_BITS+VW];
               upd_in     = 1'b0;
               res_st_in  = bpe_pkg::STATUS_OK;
               res_pos_in = '0;
               res_env_in = '0;
               state_in   = ST_CMP;
            end
         end
         ST_CMP: state_in = ST_SEL;
         ST_SEL: state_in = ST_EXEC;
         ST_EXEC: begin
            state_in = ST_DONE;
            case (func_ff)
               bpe_pkg::FUNC_INSERT: begin
                  if ((CW'(pos_ff) < count_ff) && (hi_f_ff == key_ff)) begin
                     tbl_mode   = TM_LOAD;
                     tbl_at     = pos_ff;
                     res_pos_in = pos_ff;
                  end else if (count_ff >= CW'(MAX_POINTS)) begin
                     res_st_in = bpe_pkg::STATUS_FULL;
                  end else begin
                     tbl_mode   = TM_PLACE;
                     tbl_at     = pos_ff;
                     res_pos_in = pos_ff;
                     count_in   = count_ff + CW'(1);
                  end
               end
               bpe_pkg::FUNC_UPDATE: begin
                  if (upd_ff) begin
                     tbl_mode   = TM_PLACE;
                     tbl_at     = pos_ff;
                     res_pos_in = pos_ff;
                     count_in   = count_ff + CW'(1);
                  end else if (CW'(idx_ff) >= count_ff) begin
                     res_st_in = bpe_pkg::STATUS_BAD_INDEX;
                  end else begin
                     // drop, then search again on the shortened table
                     tbl_mode = TM_DROP;
                     tbl_at   = idx_ff;
                     count_in = count_ff - CW'(1);
                     upd_in   = 1'b1;
                     state_in = ST_CMP;
                  end
               end
               bpe_pkg::FUNC_REMOVE: begin
                  if (CW'(idx_ff) >= count_ff) begin
                     res_st_in = bpe_pkg::STATUS_BAD_INDEX;
                  end else begin
                     tbl_mode = TM_DROP;
                     tbl_at   = idx_ff;
                     count_in = count_ff - CW'(1);
                  end
               end
               bpe_pkg::FUNC_EVAL: begin
                  if (count_ff == '0 || clip_ff == '0) begin
                     res_env_in = '0;
                  end else if (first_ff) begin
                     if (hi_f_ff == '0) begin
                        res_env_in = hi_v_ff;
                     end else begin
                        num_in   = key_ff;
                        den_in   = hi_f_ff;
                        coef_in  = (VW+1)'(hi_v_ff);
                        base_in  = '0;
                        inv_in   = 1'b0;
                        state_in = ST_DIV;
                     end
                  end else if (key_ff >= last_f_ff) begin
                     if (clip_ff <= last_f_ff) begin
                        res_env_in = last_v_ff;
                     end else begin
                        num_in   = key_ff - last_f_ff;
                        den_in   = clip_ff - last_f_ff;
                        coef_in  = (VW+1)'(last_v_ff);
                        base_in  = '0;
                        inv_in   = 1'b1;
                        state_in = ST_DIV;
                     end
                  end else begin
                     num_in   = key_ff - lo_f_ff;
                     den_in   = hi_f_ff - lo_f_ff;
                     coef_in  = (VW+1)'(hi_v_ff) - (VW+1)'(lo_v_ff);
                     base_in  = lo_v_ff;
                     inv_in   = 1'b0;
                     state_in = ST_DIV;
                  end
                  if (state_in == ST_DIV) div_start_in = 1'b1;
               end
               bpe_pkg::FUNC_CLEAR: count_in = '0;
               default: ;
            endcase
         end
         ST_DIV: begin
            if (div_done) state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PRW'(coef_ff) * PRW'(tt);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            res_env_in = VW'(PRW'(base_ff) + scaled);
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DW'({count_ff, res_env_ff, res_pos_ff, res_st_ff});
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         clip_ff      <= '0;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clip_ff      <= clip_in;
         upd_ff       <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
         div_start_ff <= div_start_in;
      end
      func_ff     <= func_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      first_ff    <= first_in;
      hi_f_ff     <= hi_f_in;
      hi_v_ff     <= hi_v_in;
      lo_f_ff     <= lo_f_in;
      lo_v_ff     <= lo_v_in;
      last_f_ff   <= last_f_in;
      last_v_ff   <= last_v_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      coef_ff     <= coef_in;
      base_ff     <= base_in;
      inv_ff      <= inv_in;
      prod_ff     <= prod_in;
      res_st_ff   <= res_st_in;
      res_pos_ff  <= res_pos_in;
      res_env_ff  <= res_env_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("point count beyond table depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("accepted item did not start");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside evaluation");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && res_st_ff == bpe_pkg::STATUS_FULL)
         |-> count_ff == CW'(MAX_POINTS))
      else $error("table full reported on a table with room");

endmodule

`default_nettype wire
